// ===== rtl/vn4_pkg.sv =====
// Shared widths and types for the 4D vector normalizer.
// No dependencies.
package vn4_pkg;
    localparam int CompBits = 16;
    localparam int FracBits = 14;
    localparam int NumComps = 4;
    localparam int MagW     = CompBits;                  // magnitude up to 2^(CompBits-1)
    localparam int SqW      = 2 * MagW;
    localparam int RadW     = 2 * (CompBits + 1);        // padded sum of squares
    localparam int LenW     = CompBits + 1;
    localparam int SqrtRemW = LenW + 3;
    localparam int QW       = FracBits + 1;
    localparam int DivRemW  = LenW + 1;
    localparam int UnitW    = FracBits + 2;
    localparam int SqrtSteps = LenW;
    localparam int DivSteps  = QW;

    typedef struct packed {
        logic [NumComps-1:0]           neg;
        logic [NumComps-1:0][MagW-1:0] mag;
        logic                          zero;
    } t_side;
endpackage

// ===== rtl/vn4_sqrt_stage.sv =====
// One registered digit step of the pipelined integer square root.
// Depends on vn4_pkg.
module vn4_sqrt_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  vn4_pkg::t_side               i_side,
    input  logic [vn4_pkg::RadW-1:0]     i_rad,
    input  logic [vn4_pkg::SqrtRemW-1:0] i_rem,
    input  logic [vn4_pkg::LenW-1:0]     i_root,
    output logic                         o_valid,
    output vn4_pkg::t_side               o_side,
    output logic [vn4_pkg::RadW-1:0]     o_rad,
    output logic [vn4_pkg::SqrtRemW-1:0] o_rem,
    output logic [vn4_pkg::LenW-1:0]     o_root
);
    import vn4_pkg::*;

    logic [SqrtRemW-1:0] rem_sh, trial;
    logic                fits;

    assign rem_sh = {i_rem[SqrtRemW-3:0], i_rad[RadW-1 -: 2]};
    assign trial  = {1'b0, i_root, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_side <= i_side;
            o_rad  <= {i_rad[RadW-3:0], 2'b00};
            o_rem  <= fits ? rem_sh - trial : rem_sh;
            o_root <= {i_root[LenW-2:0], fits};
        end
    end
endmodule

// ===== rtl/vn4_div_stage.sv =====
// One registered quotient bit of the four-lane restoring divider.
// Depends on vn4_pkg.
module vn4_div_stage (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  vn4_pkg::t_side                          i_side,
    input  logic [vn4_pkg::LenW-1:0]                i_len,
    input  logic [vn4_pkg::NumComps-1:0][vn4_pkg::DivRemW-1:0] i_rem,
    input  logic [vn4_pkg::NumComps-1:0][vn4_pkg::QW-1:0]      i_dvd,
    input  logic [vn4_pkg::NumComps-1:0][vn4_pkg::QW-1:0]      i_q,
    output logic                                    o_valid,
    output vn4_pkg::t_side                          o_side,
    output logic [vn4_pkg::LenW-1:0]                o_len,
    output logic [vn4_pkg::NumComps-1:0][vn4_pkg::DivRemW-1:0] o_rem,
    output logic [vn4_pkg::NumComps-1:0][vn4_pkg::QW-1:0]      o_dvd,
    output logic [vn4_pkg::NumComps-1:0][vn4_pkg::QW-1:0]      o_q
);
    import vn4_pkg::*;

    logic [NumComps-1:0][DivRemW-1:0] rem_sh;
    logic [NumComps-1:0]              fits;

    always_comb begin
        for (int i = 0; i < NumComps; i++) begin
            rem_sh[i] = {i_rem[i][DivRemW-2:0], i_dvd[i][QW-1]};
            fits[i]   = rem_sh[i] >= {1'b0, i_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_side <= i_side;
            o_len  <= i_len;
            for (int i = 0; i < NumComps; i++) begin
                o_rem[i] <= fits[i] ? rem_sh[i] - {1'b0, i_len} : rem_sh[i];
                o_dvd[i] <= {i_dvd[i][QW-2:0], 1'b0};
                o_q[i]   <= {i_q[i][QW-2:0], fits[i]};
            end
        end
    end
endmodule

// ===== rtl/vector_normalize_4d.sv =====
// Throughput: one transaction per cycle while the output is not stalled; the 17-step
//   root and 15-step divider are fully unrolled into registered stages.
// A stall on the output freezes the whole pipeline; bubbles are kept.
// Reset (i_rst_n, synchronous, active low) clears all stage valid bits.
// Depends on vn4_pkg, vn4_sqrt_stage, vn4_div_stage.
module vector_normalize_4d (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [15:0]          i_comp_x,
    input  logic signed [15:0]          i_comp_y,
    input  logic signed [15:0]          i_comp_z,
    input  logic signed [15:0]          i_comp_w,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [16:0]                 o_length,
    output logic signed [15:0]          o_unit_x,
    output logic signed [15:0]          o_unit_y,
    output logic signed [15:0]          o_unit_z,
    output logic signed [15:0]          o_unit_w,
    output logic                        o_was_zero
);
    import vn4_pkg::*;

    // single enable for every stage: move unless the output is held
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // stage 1: magnitudes and signs
    logic [NumComps-1:0][CompBits-1:0] comp_in;
    assign comp_in = {i_comp_w, i_comp_x, i_comp_y, i_comp_z} == '0 ? '0 :
                     {i_comp_w, i_comp_z, i_comp_y, i_comp_x};

    logic  r_v1, r_v2, r_v3;
    t_side r_s1, r_s2, r_s3;
    logic [NumComps-1:0][SqW-1:0] r_sq;
    logic [RadW-1:0]              r_sum;

    t_side n_s1;
    always_comb begin
        n_s1 = '0;
        for (int i = 0; i < NumComps; i++) begin
            n_s1.neg[i] = comp_in[i][CompBits-1];
            n_s1.mag[i] = comp_in[i][CompBits-1] ? MagW'(-comp_in[i]) : comp_in[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (en) begin
            r_s1 <= n_s1;
            // stage 2: one 16x16 square per lane
            r_s2 <= r_s1;
            for (int i = 0; i < NumComps; i++) begin
                r_sq[i] <= r_s1.mag[i] * r_s1.mag[i];
            end
            // stage 3: sum of squares, zero detect on magnitudes
            r_s3      <= {r_s2.neg, r_s2.mag, r_s2.mag == '0};
            r_sum     <= RadW'(r_sq[0]) + RadW'(r_sq[1]) + RadW'(r_sq[2]) + RadW'(r_sq[3]);
        end
    end

    // square root pipeline, one result bit per stage
    logic  [SqrtSteps:0]               sq_v;
    t_side [SqrtSteps:0]               sq_s;
    logic  [SqrtSteps:0][RadW-1:0]     sq_rad;
    logic  [SqrtSteps:0][SqrtRemW-1:0] sq_rem;
    logic  [SqrtSteps:0][LenW-1:0]     sq_root;

    assign sq_v[0]    = r_v3;
    assign sq_s[0]    = r_s3;
    assign sq_rad[0]  = r_sum;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
        vn4_sqrt_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[k]),
            .i_side  (sq_s[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .o_valid (sq_v[k+1]),
            .o_side  (sq_s[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1])
        );
    end

    // divider pipeline: (mag << FracBits) / len; bits above the quotient's
    // top are always zero since mag <= len, so the remainder starts at mag >> 1
    logic  [DivSteps:0]                              dv_v;
    t_side [DivSteps:0]                              dv_s;
    logic  [DivSteps:0][LenW-1:0]                    dv_len;
    logic  [DivSteps:0][NumComps-1:0][DivRemW-1:0]   dv_rem;
    logic  [DivSteps:0][NumComps-1:0][QW-1:0]        dv_dvd;
    logic  [DivSteps:0][NumComps-1:0][QW-1:0]        dv_q;

    assign dv_v[0]   = sq_v[SqrtSteps];
    assign dv_s[0]   = sq_s[SqrtSteps];
    assign dv_len[0] = sq_root[SqrtSteps];
    assign dv_q[0]   = '0;
    for (genvar i = 0; i < NumComps; i++) begin : g_div_in
        assign dv_rem[0][i] = DivRemW'(sq_s[SqrtSteps].mag[i] >> 1);
        assign dv_dvd[0][i] = {sq_s[SqrtSteps].mag[i][0], {(QW-1){1'b0}}};
    end

    for (genvar k = 0; k < DivSteps; k++) begin : g_div
        vn4_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[k]),
            .i_side  (dv_s[k]),
            .i_len   (dv_len[k]),
            .i_rem   (dv_rem[k]),
            .i_dvd   (dv_dvd[k]),
            .i_q     (dv_q[k]),
            .o_valid (dv_v[k+1]),
            .o_side  (dv_s[k+1]),
            .o_len   (dv_len[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_dvd   (dv_dvd[k+1]),
            .o_q     (dv_q[k+1])
        );
    end

    // output stage: apply signs, zero vector gives (1.0, 0, 0, 0)
    t_side dv_last;
    logic [NumComps-1:0][UnitW-1:0] n_unit;
    assign dv_last = dv_s[DivSteps];
    always_comb begin
        for (int i = 0; i < NumComps; i++) begin
            n_unit[i] = dv_last.neg[i] ? -UnitW'(dv_q[DivSteps][i]) : UnitW'(dv_q[DivSteps][i]);
        end
        if (dv_last.zero) begin
            n_unit    = '0;
            n_unit[0] = UnitW'(1) << FracBits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= dv_v[DivSteps];
        end
        if (en) begin
            o_length   <= dv_last.zero ? '0 : dv_len[DivSteps];
            o_unit_x   <= n_unit[0];
            o_unit_y   <= n_unit[1];
            o_unit_z   <= n_unit[2];
            o_unit_w   <= n_unit[3];
            o_was_zero <= dv_last.zero;
        end
    end

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_zero |-> o_length == '0) else $error("zero vector with length");
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_was_zero |-> o_length != '0) else $error("nonzero vector, zero length");
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_unit_x <= 16'sd16384 && o_unit_x >= -16'sd16384)
        else $error("unit component out of range");
endmodule

// ===== sim/vector_normalize_4d_tb.sv =====
`timescale 1ns / 100ps
// Testbench for vector_normalize_4d: length and Q1.14 unit vector of a 4D vector.
// Depends on vector_normalize_4d and its package vn4_pkg; self-checking scoreboard.

class norm_scoreboard;
    typedef struct {
        logic [16:0]        length;
        logic signed [15:0] unit [4];
        logic               was_zero;
    } norm_result_t;

    norm_result_t pending[$];
    int errors = 0;

    // Bit-serial floor root of the sum of squares.
    function automatic logic [16:0] floor_root(logic [33:0] n);
        logic [33:0] res;
        logic [33:0] bit_w;
        res = 0;
        bit_w = 34'h1 << 32;
        while (bit_w > n) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (n >= res + bit_w) begin
                n = n - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res[16:0];
    endfunction

    function void note_vector(logic signed [15:0] c [4]);
        norm_result_t r;
        logic [16:0] mag [4];
        logic [33:0] sum;
        logic [31:0] q;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = c[i][15] ? (17'h10000 - {1'b0, c[i]}) : {1'b0, c[i]};
            sum += mag[i] * mag[i];
        end
        if (sum == 0) begin
            r.length = 0;
            r.unit[0] = 16'sd16384;
            for (int i = 1; i < 4; i++) r.unit[i] = 0;
            r.was_zero = 1;
        end else begin
            r.length = floor_root(sum);
            for (int i = 0; i < 4; i++) begin
                q = ({15'b0, mag[i]} << 14) / r.length;
                r.unit[i] = c[i][15] ? -q[15:0] : q[15:0];
            end
            r.was_zero = 0;
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic [16:0] len, logic signed [15:0] u [4], logic wz);
        norm_result_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result length=%0d", $time, len);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (len !== e.length) begin
            $display("%0t: length exp %0d got %0d", $time, e.length, len);
            errors++;
        end
        for (int i = 0; i < 4; i++)
            if (u[i] !== e.unit[i]) begin
                $display("%0t: unit[%0d] exp %0d got %0d", $time, i, e.unit[i], u[i]);
                errors++;
            end
        if (wz !== e.was_zero) begin
            $display("%0t: was_zero exp %0b got %0b", $time, e.was_zero, wz);
            errors++;
        end
    endfunction
endclass

module vector_normalize_4d_tb;
    localparam int Latency = 36;
    localparam int RandomVectors = 1930;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    logic signed [15:0] comp_x = 0, comp_y = 0, comp_z = 0, comp_w = 0;
    logic o_stall, o_valid, o_was_zero;
    logic [16:0] o_length;
    logic signed [15:0] o_unit_x, o_unit_y, o_unit_z, o_unit_w;

    norm_scoreboard board = new();
    bit send_done = 0;
    bit hold_off = 0;   // long receiver hold-off request

    vector_normalize_4d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_comp_x(comp_x), .i_comp_y(comp_y), .i_comp_z(comp_z), .i_comp_w(comp_w),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_length(o_length), .o_unit_x(o_unit_x), .o_unit_y(o_unit_y),
        .o_unit_z(o_unit_z), .o_unit_w(o_unit_w), .o_was_zero(o_was_zero)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, occasionally long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(0, 16)) - 8);
            4: return 16'($urandom_range(0, 255)) << $urandom_range(0, 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one vector and holds it until the transaction is accepted.
    task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               logic [15:0] w, bit allow_gap);
        int g;
        g = allow_gap ? gap_len() : 0;
        repeat (g) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        comp_x <= x; comp_y <= y; comp_z <= z; comp_w <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_vector('{x, y, z, w});
    endtask

    // Input side: directed corners, then random vectors.
    initial begin
        logic [15:0] d [0:19][4];
        d = '{
            '{16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{16'h8000, 16'h8000, 16'h8000, 16'h8000},
            '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
            '{16'h8000, 16'h0000, 16'h0000, 16'h0000},
            '{16'h0000, 16'h8000, 16'h0000, 16'h0000},
            '{16'h0000, 16'h0000, 16'h8000, 16'h0000},
            '{16'h0000, 16'h0000, 16'h0000, 16'h8000},
            '{16'h0001, 16'h0000, 16'h0000, 16'h0000},
            '{16'hffff, 16'h0000, 16'h0000, 16'h0000},
            '{16'h0000, 16'h0000, 16'h0000, 16'hffff},
            '{16'h0001, 16'h0001, 16'h0001, 16'h0001},
            '{16'hffff, 16'hffff, 16'hffff, 16'hffff},
            '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000},
            '{16'h0003, 16'h0004, 16'h0000, 16'h0000},
            '{16'h0001, 16'h0001, 16'h0000, 16'h0000},
            '{16'h5555, 16'haaaa, 16'h00ff, 16'hff00},
            '{16'h0000, 16'h7fff, 16'h0000, 16'h0001},
            '{16'h8001, 16'h0001, 16'h8001, 16'h0001},
            '{16'h0002, 16'hfffe, 16'h0002, 16'hfffe},
            '{16'h1234, 16'h0000, 16'h0000, 16'h0000}
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        for (int i = 0; i < 20; i++)
            send_vector(d[i][0], d[i][1], d[i][2], d[i][3], i > 10);
        for (int i = 0; i < RandomVectors; i++) begin
            if (i == 300) hold_off = 1;   // sender keeps offering into the hold-off
            send_vector(rand_comp(), rand_comp(), rand_comp(), rand_comp(), i % 200 > 30);
        end
        i_valid <= 0;
        send_done = 1;
    end

    // Output side: random stalls plus one long hold-off to back up the pipeline.
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                hold_off = 0;
                i_stall <= 1;
                repeat (120) @(posedge i_clk);
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0) begin
                i_stall <= 1;
                repeat (g) @(posedge i_clk);
            end
            i_stall <= 0;
            @(posedge i_clk);
        end
    end

    // Result check on each completed output transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_length, '{o_unit_x, o_unit_y, o_unit_z, o_unit_w},
                               o_was_zero);
    end

    // Drain, then report.
    initial begin
        wait (send_done);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
